[sv/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
package rhsv_pkg;

  localparam int CompW    = 8;   // one color component
  localparam int HueW     = 9;   // hue quotient, 0..359
  localparam int SatW     = 7;   // saturation quotient, 0..100
  localparam int ValW     = 7;   // brightness, 0..100
  localparam int HueRemW  = 17;  // hue numerator, below 360*255
  localparam int SatRemW  = 15;  // saturation numerator, up to 100*255
  localparam int DivSteps = 3;   // quotient bits resolved per divider stage
  localparam int DivStages = (HueW + DivSteps - 1) / DivSteps;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [ValW-1:0] brightness;
  } hsv_t;

  // One item in flight through the divider stages.
  typedef struct packed {
    logic               vld;
    logic [HueRemW-1:0] hue_rem;
    logic [CompW-1:0]   hue_div;
    logic [HueW-1:0]    hue_q;
    logic [SatRemW-1:0] sat_rem;
    logic [CompW-1:0]   sat_div;
    logic [SatW-1:0]    sat_q;
    logic [ValW-1:0]    val;
  } stage_t;

endpackage

[sv/rhsv_stream_if.sv]
// Valid/ready stream channel carrying one payload item per handshake.
interface rhsv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/rgb_to_hsv_pixel_top.sv]
// Top level of the RGB to HSV pixel converter.
//
//   channel  dir  payload                           handshake
//   px       in   red, green, blue (8 b each)       valid/ready
//   hsv      out  hue (9 b), saturation, brightness  valid/ready
//                 (7 b each)
//
// One item is taken every cycle while the output is not stalled.
// Two front stages find max/min and the numerators, then three division
// stages resolve three hue quotient bits each; the seven saturation bits
// split as three, three and one.
// Reset clears only the stage valid bits; payload is left as is.
// A stall at the output freezes every stage at once, so px.ready drops
// only while the last stage holds an item that is not yet taken.
module rgb_to_hsv_pixel_top (
  input  logic clk,
  input  logic rst,
  rhsv_stream_if.sink   px,
  rhsv_stream_if.source hsv
);
  import rhsv_pkg::*;

  logic   en;
  stage_t st [DivStages+1];

  // whole pipe moves when the output register is empty or being drained
  assign en       = !st[DivStages].vld || hsv.ready;
  assign px.ready = en;

  rhsv_front u_front (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vld (px.valid),
    .pix (px.data),
    .q   (st[0])
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    rhsv_div_stage #(
      .Stage (k)
    ) u_div (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .d_in (st[k]),
      .q    (st[k+1])
    );
  end

  // last division stage is the output register
  assign hsv.valid           = st[DivStages].vld;
  assign hsv.data.hue        = st[DivStages].hue_q;
  assign hsv.data.saturation = st[DivStages].sat_q;
  assign hsv.data.brightness = st[DivStages].val;

`ifndef ASSERT_OFF
  // results always land in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> (hsv.data.hue <= 9'd359) && (hsv.data.saturation <= 7'd100)
                  && (hsv.data.brightness <= 7'd100))
    else $error("hsv result out of range");

  // a held output blocks new input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && !hsv.ready) |-> !px.ready)
    else $error("input taken while output stalled");

  // a stalled result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && !hsv.ready) |=> hsv.valid && $stable(hsv.data))
    else $error("stalled result changed");
`endif
endmodule

[sv/rhsv_front.sv]
// Front end: max/min/sector select, then hue/saturation numerators and brightness.
module rhsv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld,
  input  rhsv_pkg::rgb_t pix,
  output rhsv_pkg::stage_t q
);
  import rhsv_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED   = 2'b00,
    SEC_GREEN = 2'b01,
    SEC_BLUE  = 2'b10
  } sector_t;

  // first register stage
  logic                    a_vld;
  logic [CompW-1:0]        a_mx;
  logic [CompW-1:0]        a_d;
  sector_t                 a_sec;
  logic signed [CompW:0]   a_diff;

  logic [CompW-1:0]        mx, mn;
  sector_t                 sec;
  logic signed [CompW:0]   diff;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx)  mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn)  mn = pix.blue;
    // red wins ties, then green
    if (pix.red == mx) begin
      sec  = SEC_RED;
      diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    end else if (pix.green == mx) begin
      sec  = SEC_GREEN;
      diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
    end else begin
      sec  = SEC_BLUE;
      diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld  <= vld;
      a_mx   <= mx;
      a_d    <= mx - mn;
      a_sec  <= sec;
      a_diff <= diff;
    end
  end

  // second stage: hue numerator with wrap, saturation numerator, brightness
  logic signed [19:0] base;
  logic signed [19:0] num;
  logic [15:0]        vx;
  logic [15:0]        vsum;
  logic               grey;
  stage_t             nxt;

  always_comb begin
    case (a_sec)
      SEC_RED:   base = 20'sd0;
      SEC_GREEN: base = $signed(20'(a_d) * 20'd120);
      SEC_BLUE:  base = $signed(20'(a_d) * 20'd240);
      default:   base = 20'sd0;
    endcase
    num = base + 20'(a_diff) * 20'sd60;
    if (num < 0) begin
      num = num + $signed(20'(a_d) * 20'd360);
    end
    // floor(x/255) = (x + 1 + (x >> 8)) >> 8 for x below 65535
    vx   = 16'(a_mx) * 16'd100;
    vsum = vx + 16'd1 + (vx >> 8);
    grey = (a_d == '0);

    nxt.vld     = a_vld;
    nxt.hue_q   = '0;
    nxt.sat_q   = '0;
    nxt.val     = vsum[8 +: ValW];
    // grey pixel: zero numerators over a unit divisor give zero quotients
    nxt.hue_rem = grey ? '0 : num[HueRemW-1:0];
    nxt.hue_div = grey ? CompW'(1) : a_d;
    nxt.sat_rem = grey ? '0 : SatRemW'(a_d) * SatRemW'(100);
    nxt.sat_div = grey ? CompW'(1) : a_mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end
endmodule

[sv/rhsv_div_stage.sv]
// One restoring-division stage: resolves DivSteps hue quotient bits and up to DivSteps saturation bits.
module rhsv_div_stage #(
  parameter int Stage = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rhsv_pkg::stage_t d_in,
  output rhsv_pkg::stage_t q
);
  import rhsv_pkg::*;

  localparam int HueHi = HueW - 1 - Stage * DivSteps;
  localparam int SatHi = SatW - 1 - Stage * DivSteps;

  stage_t nxt;

  always_comb begin
    int                 hb;
    int                 sb;
    logic [HueRemW-1:0] hsub;
    logic [SatRemW-1:0] ssub;
    nxt = d_in;
    for (int j = 0; j < DivSteps; j++) begin
      hb = HueHi - j;
      sb = SatHi - j;
      if (hb >= 0) begin
        hsub = HueRemW'(nxt.hue_div) << hb;
        if (nxt.hue_rem >= hsub) begin
          nxt.hue_rem      = nxt.hue_rem - hsub;
          nxt.hue_q[hb[3:0]] = 1'b1;
        end
      end
      if (sb >= 0) begin
        ssub = SatRemW'(nxt.sat_div) << sb;
        if (nxt.sat_rem >= ssub) begin
          nxt.sat_rem      = nxt.sat_rem - ssub;
          nxt.sat_q[sb[2:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end
endmodule

[verif/tb_rgb_to_hsv_pixel_top.sv]
// Self-checking testbench for the RGB to HSV pixel converter top level.
module tb_rgb_to_hsv_pixel_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhsv_pkg::*;

  logic clk;
  logic rst = 1'b1;

  rhsv_stream_if #(.T(rgb_t)) px_if ();
  rhsv_stream_if #(.T(hsv_t)) hsv_if ();

  rgb_to_hsv_pixel_top uut (
    .clk (clk),
    .rst (rst),
    .px  (px_if.sink),
    .hsv (hsv_if.source)
  );

  // 12 ns period; starts low so time-zero init settles before the first edge.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Pixels waiting to be driven, and converted results still owed by the DUT.
  rgb_t pixel_q[$];
  hsv_t hsv_due[$];

  int n_sent    = 0;
  int n_checked = 0;
  int n_bad     = 0;

  // Idle state of the two sides.
  int src_gap  = 0;
  int src_calm = 0;
  int snk_gap  = 0;
  int snk_calm = 0;

  // Exact-integer conversion. Max/min pick the sector; red wins ties over
  // green, green over blue. A negative hue numerator wraps by a full turn
  // (360*d) before the floor division.
  function automatic hsv_t rgb_to_hsv_exact(rgb_t p);
    int   r, g, b, mx, mn, d, num;
    hsv_t h;
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    h.brightness = ValW'(100 * mx / 255);
    if (d == 0) begin
      // grey: no hue, no saturation
      h.hue        = '0;
      h.saturation = '0;
    end else begin
      h.saturation = SatW'(100 * d / mx);
      if (r == mx) begin
        num = 60 * (g - b);
      end else if (g == mx) begin
        num = 120 * d + 60 * (b - r);
      end else begin
        num = 240 * d + 60 * (r - g);
      end
      if (num < 0) num += 360 * d;
      h.hue = HueW'(num / d);
    end
    return h;
  endfunction

  // Idle length: mostly none or short, a few long, and now and then a calm
  // stretch with no idling at all.
  function automatic int idle_len(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 90);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp8(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic void add_pixel(int r, int g, int b);
    rgb_t p;
    p.red   = CompW'(r);
    p.green = CompW'(g);
    p.blue  = CompW'(b);
    pixel_q.push_back(p);
  endfunction

  function automatic int corner_val();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return 254;
      default: return 255;
    endcase
  endfunction

  // Random pixel drawn from a mix of classes so that greys, near-greys,
  // tied maxima and saturated corners show up far more often than in a
  // plain uniform draw.
  function automatic void add_random_pixel();
    int c[3];
    int hi, lo, base, k;
    case ($urandom_range(0, 9))
      4: begin // near grey, small spread
        base = $urandom_range(0, 255);
        for (k = 0; k < 3; k++) c[k] = clamp8(base + int'($urandom_range(0, 6)) - 3);
      end
      5: begin // two components tie for the maximum
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi - 1);
        k  = $urandom_range(0, 2);
        c[0] = hi;
        c[1] = hi;
        c[2] = hi;
        c[k] = lo;
      end
      6: begin
        for (k = 0; k < 3; k++) c[k] = corner_val();
      end
      7: begin // exact grey
        base = $urandom_range(0, 255);
        for (k = 0; k < 3; k++) c[k] = base;
      end
      8: begin
        for (k = 0; k < 3; k++) c[k] = $urandom_range(0, 255);
        c[$urandom_range(0, 2)] = 255;
      end
      9: begin
        for (k = 0; k < 3; k++) c[k] = $urandom_range(0, 255);
        c[$urandom_range(0, 2)] = 0;
      end
      default: begin
        for (k = 0; k < 3; k++) c[k] = $urandom_range(0, 255);
      end
    endcase
    add_pixel(c[0], c[1], c[2]);
  endfunction

  // Pixel driver: a new item goes up only once the previous one is taken
  // (or nothing is up), after its random gap has run out.
  always @(posedge clk) begin
    if (rst) begin
      px_if.valid <= 1'b0;
      src_gap     <= 0;
    end else if (!px_if.valid || px_if.ready) begin
      if (src_gap > 0) begin
        px_if.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (pixel_q.size() > 0) begin
        px_if.data  <= pixel_q.pop_front();
        px_if.valid <= 1'b1;
        src_gap     <= idle_len(src_calm);
      end else begin
        px_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: ready is held high between random stalls.
  always @(posedge clk) begin
    if (rst) begin
      hsv_if.ready <= 1'b0;
      snk_gap      <= 0;
    end else if (snk_gap > 0) begin
      hsv_if.ready <= 1'b0;
      snk_gap      <= snk_gap - 1;
    end else begin
      hsv_if.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) snk_gap <= idle_len(snk_calm);
    end
  end

  // Monitor: every accepted pixel queues its expected result; every
  // accepted result is checked against the oldest one owed.
  always @(posedge clk) begin : check_hsv
    hsv_t want;
    hsv_t got;
    if (!rst) begin
      if (px_if.valid && px_if.ready) begin
        hsv_due.push_back(rgb_to_hsv_exact(px_if.data));
        n_sent++;
      end
      if (hsv_if.valid && hsv_if.ready) begin
        got = hsv_if.data;
        if (hsv_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("hsv item with nothing owed: hue %0d sat %0d val %0d",
                     got.hue, got.saturation, got.brightness);
        end else begin
          want = hsv_due.pop_front();
          n_checked++;
          if (got.hue !== want.hue || got.saturation !== want.saturation ||
              got.brightness !== want.brightness) begin
            n_bad++;
            if (n_bad <= 10)
              $display("hsv mismatch: expected hue %0d sat %0d val %0d,",
                       want.hue, want.saturation, want.brightness,
                       " got hue %0d sat %0d val %0d",
                       got.hue, got.saturation, got.brightness);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    px_if.valid  = 1'b0;
    px_if.data   = '0;
    hsv_if.ready = 1'b0;

    // Directed: greys incl. black and white, primaries, ties for the
    // maximum, hue that goes negative and wraps, and off-by-one corners.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);     // red/green tie, red wins
    add_pixel(0, 255, 255);     // green/blue tie, green wins
    add_pixel(255, 0, 255);     // red/blue tie, red wins, hue wraps
    add_pixel(255, 0, 1);       // slightly negative hue
    add_pixel(255, 1, 0);
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(254, 255, 255);
    add_pixel(255, 254, 254);
    add_pixel(10, 200, 200);
    add_pixel(200, 10, 200);
    add_pixel(200, 200, 10);
    add_pixel(255, 128, 0);
    add_pixel(0, 128, 255);
    add_pixel(100, 0, 255);
    add_pixel(170, 85, 170);

    for (i = 0; i < 1400; i++) add_random_pixel();

    wait (!rst);
    // all pixels taken and every owed result back
    while (pixel_q.size() > 0 || px_if.valid || hsv_due.size() > 0)
      @(posedge clk);
    // drain window well over the pipeline depth to catch stray results
    repeat (12) @(posedge clk);

    $display("%0d pixels converted, %0d results compared (greys, tied maxima,",
             n_sent, n_checked);
    $display("hue wrap, near-grey and random streams under random stalls); %0d bad",
             n_bad);
    if (n_bad == 0) begin
      $display("rgb_to_hsv_pixel_top verification clean");
    end else begin
      $display("rgb_to_hsv_pixel_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (long gaps on both sides
  // for every pixel plus pipeline latency).
  initial begin
    #20_000_000;
    $display("timeout: %0d results still owed", hsv_due.size());
    $display("rgb_to_hsv_pixel_top verification failed");
    $finish;
  end

endmodule
